[src/convex_support_point_unit_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the convex support-point unit.
// Short wrappers that give each concurrent check its clock, its disabling reset
// and an error report.
// ---------------------------------------------------------------------------
`ifndef CONVEX_SUPPORT_POINT_UNIT_CORE_MACROS_SVH
`define CONVEX_SUPPORT_POINT_UNIT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define CSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[src/csp_pkg.sv]
// ---------------------------------------------------------------------------
// Convex support-point unit package
// Widths, types, shape codes and stage bookkeeping shared by all modules.
// ---------------------------------------------------------------------------
package csp_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int UNIT_FRAC_BITS = 14;

   localparam int NVERT    = 6;
   localparam int VIDX_W   = $clog2(NVERT);
   localparam int PNT_W    = 3 * COORD_WIDTH;
   localparam int RAD_W    = COORD_WIDTH - 1;
   localparam int PROD_W   = 2 * COORD_WIDTH;
   localparam int DOT_W    = 2 * COORD_WIDTH + 2;
   localparam int LEN_W    = 2 * COORD_WIDTH;
   localparam int SQ_W     = 2 * COORD_WIDTH - 1;
   localparam int UM_W     = UNIT_FRAC_BITS + 1;
   localparam int R_W      = SQ_W + 2 * UNIT_FRAC_BITS + 2;
   localparam int P_W      = 2 * COORD_WIDTH + 2 * UNIT_FRAC_BITS + 4;
   localparam int Q_W      = 2 * COORD_WIDTH + UNIT_FRAC_BITS + 2;
   localparam int MP_W     = RAD_W + UM_W;
   localparam int SUM_W    = COORD_WIDTH + 2;
   localparam int NORM_ST  = UNIT_FRAC_BITS + 1;
   localparam int NORM0    = 4;
   localparam int NST      = NORM0 + NORM_ST + 2;
   localparam int IN_W     = ((PNT_W * (NVERT + 1) + RAD_W + 7) / 8) * 8;
   localparam int OUT_W    = ((PNT_W + 7) / 8) * 8;

   typedef logic        [1:0]             func_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef coord_type   [2:0]             point_type;
   typedef point_type   [NVERT-1:0]       verts_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic        [LEN_W-1:0]       len_type;
   typedef logic        [SQ_W-1:0]        sq_type;
   typedef logic        [UM_W-1:0]        um_type;
   typedef logic        [R_W-1:0]         rr_type;
   typedef logic        [P_W-1:0]         pp_type;
   typedef logic signed [Q_W-1:0]         qq_type;
   typedef logic signed [P_W:0]           wide_type;
   typedef logic        [RAD_W-1:0]       rad_type;
   typedef logic        [VIDX_W-1:0]      vidx_type;
   typedef logic        [MP_W-1:0]        mprod_type;
   typedef logic        [MP_W:0]          rnd_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   localparam func_type FUNC_TRI          = 2'd0;
   localparam func_type FUNC_SWEPT_TRI    = 2'd1;
   localparam func_type FUNC_SPHERE       = 2'd2;
   localparam func_type FUNC_SWEPT_SPHERE = 2'd3;

   localparam um_type    UNIT_ONE  = um_type'(1) << UNIT_FRAC_BITS;
   localparam rnd_type   RND_HALF  = rnd_type'(1) << (UNIT_FRAC_BITS - 1);
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   // Result of the vertex selection stages.
   typedef struct packed {
      logic      sphere;
      point_type point;
   } pick_type;

   // Side information carried beside the dot-product stages.
   typedef struct packed {
      func_type    func;
      verts_type   verts;
      rad_type     radius;
      logic [2:0]  neg;
   } side_a_type;

   // Side information carried beside the selection stages.
   typedef struct packed {
      len_type          len2;
      sq_type [2:0]     sq;
      rad_type          radius;
      logic [2:0]       neg;
   } side_b_type;

   // Side information carried beside the normalizer stages.
   typedef struct packed {
      logic        zero;
      rad_type     radius;
      logic [2:0]  neg;
      pick_type    pick;
   } side_c_type;

endpackage

[src/csp_dot.sv]
// ---------------------------------------------------------------------------
// Dot-product stages
// Stage one forms all coordinate products and direction squares, stage two
// sums them per vertex and into the squared direction length.
module csp_dot (
   input  logic                                         clock,
   input  logic                                         en0,
   input  logic                                         en1,
   input  csp_pkg::point_type                           dir,
   input  csp_pkg::verts_type                           verts,
   output csp_pkg::dot_type [csp_pkg::NVERT-1:0]        dot_ff,
   output csp_pkg::len_type                             len2_ff,
   output csp_pkg::sq_type  [2:0]                       sq_ff
);

   csp_pkg::prod_type [csp_pkg::NVERT-1:0][2:0] prod_ff, prod_in;
   csp_pkg::prod_type [2:0]                     dsq_ff, dsq_in;
   csp_pkg::dot_type  [csp_pkg::NVERT-1:0]      dot_in;
   csp_pkg::len_type                            len2_in;
   csp_pkg::sq_type   [2:0]                     sq_in;

   always_comb begin
      for (int v = 0; v < csp_pkg::NVERT; v++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[v][k] = $signed(verts[v][k]) * $signed(dir[k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         dsq_in[k] = $signed(dir[k]) * $signed(dir[k]);
      end
   end

   always_comb begin
      for (int v = 0; v < csp_pkg::NVERT; v++) begin
         dot_in[v] = csp_pkg::dot_type'(prod_ff[v][0]) + csp_pkg::dot_type'(prod_ff[v][1])
                   + csp_pkg::dot_type'(prod_ff[v][2]);
      end
      // The squares are never negative, so they sum as unsigned values.
      len2_in = csp_pkg::len_type'(dsq_ff[0]) + csp_pkg::len_type'(dsq_ff[1])
              + csp_pkg::len_type'(dsq_ff[2]);
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = dsq_ff[k][csp_pkg::SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         prod_ff <= prod_in;
         dsq_ff  <= dsq_in;
      end
      if (en1) begin
         dot_ff  <= dot_in;
         len2_ff <= len2_in;
         sq_ff   <= sq_in;
      end
   end

endmodule

[src/csp_pick.sv]
// ---------------------------------------------------------------------------
// Vertex selection stages
// Stage one decides triangle and sphere picks and reduces the swept triangle
// to three pair winners; stage two finishes the choice and muxes the vertex.
// ---------------------------------------------------------------------------
module csp_pick (
   input  logic                                  clock,
   input  logic                                  en0,
   input  logic                                  en1,
   input  csp_pkg::func_type                     func,
   input  csp_pkg::dot_type [csp_pkg::NVERT-1:0] dots,
   input  csp_pkg::verts_type                    verts,
   output csp_pkg::pick_type                     pick_ff
);

   csp_pkg::func_type           func_ff;
   csp_pkg::verts_type          verts_ff;
   csp_pkg::vidx_type           fix_ff, fix_in;
   csp_pkg::vidx_type [2:0]     wi_ff, wi_in;
   csp_pkg::dot_type  [2:0]     wv_ff, wv_in;
   csp_pkg::pick_type           pick_in;

   always_comb begin
      case (func)
         csp_pkg::FUNC_TRI: begin
            if (dots[0] > dots[1] && dots[0] > dots[2]) begin
               fix_in = csp_pkg::vidx_type'(0);
            end else if (dots[1] > dots[2]) begin
               fix_in = csp_pkg::vidx_type'(1);
            end else begin
               fix_in = csp_pkg::vidx_type'(2);
            end
         end
         csp_pkg::FUNC_SWEPT_SPHERE: begin
            fix_in = (dots[0] > dots[1]) ? csp_pkg::vidx_type'(0) : csp_pkg::vidx_type'(1);
         end
         default: begin
            fix_in = csp_pkg::vidx_type'(0);
         end
      endcase
      // On a tie the lower index stays, which keeps the first maximum.
      for (int p = 0; p < 3; p++) begin
         if (dots[2*p+1] > dots[2*p]) begin
            wi_in[p] = csp_pkg::vidx_type'(2*p+1);
            wv_in[p] = dots[2*p+1];
         end else begin
            wi_in[p] = csp_pkg::vidx_type'(2*p);
            wv_in[p] = dots[2*p];
         end
      end
   end

   always_comb begin
      csp_pkg::vidx_type bi;
      csp_pkg::dot_type  bv;
      bi = wi_ff[0];
      bv = wv_ff[0];
      if (wv_ff[1] > bv) begin
         bi = wi_ff[1];
         bv = wv_ff[1];
      end
      if (wv_ff[2] > bv) begin
         bi = wi_ff[2];
      end
      if (func_ff != csp_pkg::FUNC_SWEPT_TRI) begin
         bi = fix_ff;
      end
      pick_in.sphere = (func_ff == csp_pkg::FUNC_SPHERE)
                    || (func_ff == csp_pkg::FUNC_SWEPT_SPHERE);
      pick_in.point  = verts_ff[bi];
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         func_ff  <= func;
         verts_ff <= verts;
         fix_ff   <= fix_in;
         wi_ff    <= wi_in;
         wv_ff    <= wv_in;
      end
      if (en1) begin
         pick_ff <= pick_in;
      end
   end

endmodule

[src/csp_norm.sv]
// ---------------------------------------------------------------------------
// Direction normalizer
// Digit-by-digit search of each unit component, one result bit per stage,
// kept exact with running square and cross terms so that each stage needs
// only shifts, additions and one compare.
// ---------------------------------------------------------------------------
module csp_norm (
   input  logic                             clock,
   input  logic [csp_pkg::NORM_ST-1:0]      en,
   input  csp_pkg::len_type                 len2,
   input  csp_pkg::sq_type  [2:0]           sq,
   output csp_pkg::um_type  [2:0]           umag
);

   // For a trial t the test is (2t-1)^2 * len2 <= 4 * comp^2 * 2^(2F).
   // p holds s^2 * len2 and q holds s * len2 for s = 2u - 1.
   csp_pkg::pp_type  p_ff   [csp_pkg::NORM_ST][3];
   csp_pkg::qq_type  q_ff   [csp_pkg::NORM_ST][3];
   csp_pkg::rr_type  r_ff   [csp_pkg::NORM_ST][3];
   csp_pkg::um_type  u_ff   [csp_pkg::NORM_ST][3];
   csp_pkg::len_type len_ff [csp_pkg::NORM_ST];

   csp_pkg::pp_type  p_in   [csp_pkg::NORM_ST][3];
   csp_pkg::qq_type  q_in   [csp_pkg::NORM_ST][3];
   csp_pkg::rr_type  r_in   [csp_pkg::NORM_ST][3];
   csp_pkg::um_type  u_in   [csp_pkg::NORM_ST][3];
   csp_pkg::len_type len_in [csp_pkg::NORM_ST];

   csp_pkg::pp_type  p_src   [csp_pkg::NORM_ST][3];
   csp_pkg::qq_type  q_src   [csp_pkg::NORM_ST][3];
   csp_pkg::rr_type  r_src   [csp_pkg::NORM_ST][3];
   csp_pkg::um_type  u_src   [csp_pkg::NORM_ST][3];
   csp_pkg::len_type len_src [csp_pkg::NORM_ST];

   always_comb begin
      len_src[0] = len2;
      for (int k = 0; k < 3; k++) begin
         p_src[0][k] = csp_pkg::pp_type'(len2);
         q_src[0][k] = -csp_pkg::qq_type'(len2);
         r_src[0][k] = csp_pkg::rr_type'(sq[k]) << (2 * csp_pkg::UNIT_FRAC_BITS + 2);
         u_src[0][k] = '0;
      end
      for (int j = 1; j < csp_pkg::NORM_ST; j++) begin
         len_src[j] = len_ff[j-1];
         for (int k = 0; k < 3; k++) begin
            p_src[j][k] = p_ff[j-1][k];
            q_src[j][k] = q_ff[j-1][k];
            r_src[j][k] = r_ff[j-1][k];
            u_src[j][k] = u_ff[j-1][k];
         end
      end
   end

   always_comb begin
      csp_pkg::wide_type pw, qs, ls, cand;
      logic              take;
      int                b;
      for (int j = 0; j < csp_pkg::NORM_ST; j++) begin
         b = csp_pkg::UNIT_FRAC_BITS - j;
         len_in[j] = len_src[j];
         for (int k = 0; k < 3; k++) begin
            pw   = csp_pkg::wide_type'(p_src[j][k]);
            qs   = csp_pkg::wide_type'(q_src[j][k]);
            ls   = csp_pkg::wide_type'(len_src[j]);
            cand = pw + (qs <<< (b + 2)) + (ls <<< (2 * b + 2));
            // Once the top bit is set the component is exactly one; no
            // further bit may be added.
            take = (cand <= csp_pkg::wide_type'(r_src[j][k]))
                && !((j != 0) && u_src[j][k][csp_pkg::UNIT_FRAC_BITS]);
            r_in[j][k] = r_src[j][k];
            if (take) begin
               u_in[j][k] = u_src[j][k] | (csp_pkg::um_type'(1) << b);
               p_in[j][k] = cand[csp_pkg::P_W-1:0];
               q_in[j][k] = q_src[j][k] + (csp_pkg::qq_type'(len_src[j]) <<< (b + 1));
            end else begin
               u_in[j][k] = u_src[j][k];
               p_in[j][k] = p_src[j][k];
               q_in[j][k] = q_src[j][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < csp_pkg::NORM_ST; j++) begin
         if (en[j]) begin
            len_ff[j] <= len_in[j];
            for (int k = 0; k < 3; k++) begin
               p_ff[j][k] <= p_in[j][k];
               q_ff[j][k] <= q_in[j][k];
               r_ff[j][k] <= r_in[j][k];
               u_ff[j][k] <= u_in[j][k];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         umag[k] = u_ff[csp_pkg::NORM_ST-1][k];
      end
   end

endmodule

[src/csp_round.sv]
// ---------------------------------------------------------------------------
// Sphere offset and output stages
// Scales the unit direction by the radius, rounds to Q8.8, adds the centre
// with saturation (spheres only) and holds the finished result.
// ---------------------------------------------------------------------------
module csp_round (
   input  logic                        clock,
   input  logic                        en0,
   input  logic                        en1,
   input  csp_pkg::side_c_type         side,
   input  csp_pkg::um_type [2:0]       umag,
   output csp_pkg::point_type          point_ff,
   output logic                        sat_ff,
   output logic                        sphere_ff
);

   csp_pkg::mprod_type [2:0] mp_ff, mp_in;
   csp_pkg::point_type       base_ff;
   logic [2:0]               neg_ff;
   logic                     sph_ff;
   csp_pkg::um_type [2:0]    m;
   csp_pkg::point_type       point_in;
   logic                     sat_in;

   always_comb begin
      // A zero direction stands for the unit x axis.
      for (int k = 0; k < 3; k++) begin
         if (side.zero) begin
            m[k] = (k == 0) ? csp_pkg::UNIT_ONE : '0;
         end else begin
            m[k] = umag[k];
         end
         mp_in[k] = csp_pkg::mprod_type'(side.radius) * csp_pkg::mprod_type'(m[k]);
      end
   end

   always_comb begin
      csp_pkg::rnd_type rnd;
      csp_pkg::sum_type s, o;
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         rnd = csp_pkg::rnd_type'(mp_ff[k]) + csp_pkg::RND_HALF;
         o   = csp_pkg::sum_type'(rnd[csp_pkg::MP_W:csp_pkg::UNIT_FRAC_BITS]);
         s   = csp_pkg::sum_type'(base_ff[k]);
         s   = neg_ff[k] ? (s - o) : (s + o);
         if (!sph_ff) begin
            point_in[k] = base_ff[k];
         end else if (s > csp_pkg::sum_type'(csp_pkg::COORD_MAX)) begin
            point_in[k] = csp_pkg::COORD_MAX;
            sat_in      = 1'b1;
         end else if (s < csp_pkg::sum_type'(csp_pkg::COORD_MIN)) begin
            point_in[k] = csp_pkg::COORD_MIN;
            sat_in      = 1'b1;
         end else begin
            point_in[k] = s[csp_pkg::COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         mp_ff   <= mp_in;
         base_ff <= side.pick.point;
         neg_ff  <= side.neg;
         sph_ff  <= side.pick.sphere;
      end
      if (en1) begin
         point_ff  <= point_in;
         sat_ff    <= sat_in;
         sphere_ff <= sph_ff;
      end
   end

endmodule

[src/convex_support_point_unit_core.sv]
// ---------------------------------------------------------------------------
// Convex support-point unit
// Returns the point of a triangle, swept triangle, sphere or swept sphere
// that lies furthest along a search direction.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                   Handshake
//   req_*     in    tuser: func; tdata: dir, v0..v5, radius   tvalid/tready
//   rsp_*     out   tdata: x, y, z; tuser: saturated          tvalid/tready
//
// Each transaction passes through 21 register stages: two for the dot
// products, two for vertex selection, fifteen for the normalizer (one unit
// bit per stage) and two for the offset and the output register.
// A new transaction is taken in every cycle unless a stalled response holds the first stage.
// Reset is synchronous and active high and clears only the stage valid bits.
// Every stage has its own enable, so a stalled result stops only the stages
// that are full behind it while empty stages keep filling.
// ---------------------------------------------------------------------------
`include "convex_support_point_unit_core_macros.svh"

module convex_support_point_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: direction, vertex_0 .. vertex_5, radius, zero fill.
   input  logic [csp_pkg::IN_W-1:0]      req_tdata,
   // Fields from bit 0: func.
   input  csp_pkg::func_type             req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: point_x, point_y, point_z.
   output logic [csp_pkg::OUT_W-1:0]     rsp_tdata,
   // Fields from bit 0: saturated.
   output logic                          rsp_tuser
);

   localparam int NST = csp_pkg::NST;

   // Stage valid bits and the per-stage load enables. A stage may load when
   // it is empty or when the stage after it is loading too.
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] en;

   assign en[NST-1] = ~valid_ff[NST-1] | rsp_tready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = ~valid_ff[k] | en[k+1];
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid & req_tready;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Unpack the request payload.
   csp_pkg::point_type dir;
   csp_pkg::verts_type verts;
   csp_pkg::rad_type   radius;

   always_comb begin
      dir    = req_tdata[0 +: csp_pkg::PNT_W];
      for (int v = 0; v < csp_pkg::NVERT; v++) begin
         verts[v] = req_tdata[csp_pkg::PNT_W * (v + 1) +: csp_pkg::PNT_W];
      end
      radius = req_tdata[csp_pkg::PNT_W * (csp_pkg::NVERT + 1) +: csp_pkg::RAD_W];
   end

   // Side information that travels beside the dot-product stages.
   csp_pkg::side_a_type side_a_ff [2];
   csp_pkg::side_a_type side_a_in;

   always_comb begin
      side_a_in.func   = req_tuser;
      side_a_in.verts  = verts;
      side_a_in.radius = radius;
      for (int k = 0; k < 3; k++) begin
         side_a_in.neg[k] = dir[k][csp_pkg::COORD_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_a_ff[0] <= side_a_in;
      end
      if (en[1]) begin
         side_a_ff[1] <= side_a_ff[0];
      end
   end

   // Dot products of every vertex and the squared length of the direction.
   csp_pkg::dot_type [csp_pkg::NVERT-1:0] dots;
   csp_pkg::len_type                      len2;
   csp_pkg::sq_type  [2:0]                sq;

   csp_dot u_dot (
      .clock   (clock),
      .en0     (en[0]),
      .en1     (en[1]),
      .dir     (dir),
      .verts   (verts),
      .dot_ff  (dots),
      .len2_ff (len2),
      .sq_ff   (sq)
   );

   // Vertex selection; the length terms ride along for the normalizer.
   csp_pkg::pick_type   pick;
   csp_pkg::side_b_type side_b_ff [2];
   csp_pkg::side_b_type side_b_in;

   csp_pick u_pick (
      .clock   (clock),
      .en0     (en[2]),
      .en1     (en[3]),
      .func    (side_a_ff[1].func),
      .dots    (dots),
      .verts   (side_a_ff[1].verts),
      .pick_ff (pick)
   );

   always_comb begin
      side_b_in.len2   = len2;
      side_b_in.sq     = sq;
      side_b_in.radius = side_a_ff[1].radius;
      side_b_in.neg    = side_a_ff[1].neg;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         side_b_ff[0] <= side_b_in;
      end
      if (en[3]) begin
         side_b_ff[1] <= side_b_ff[0];
      end
   end

   // Normalizer. Polygon transactions flow through it too; their unit
   // components are simply ignored at the end.
   csp_pkg::um_type     [2:0] umag;
   csp_pkg::side_c_type       side_c_ff [csp_pkg::NORM_ST];
   csp_pkg::side_c_type       side_c_in;

   csp_norm u_norm (
      .clock (clock),
      .en    (en[csp_pkg::NORM0 +: csp_pkg::NORM_ST]),
      .len2  (side_b_ff[1].len2),
      .sq    (side_b_ff[1].sq),
      .umag  (umag)
   );

   always_comb begin
      side_c_in.zero   = (side_b_ff[1].len2 == '0);
      side_c_in.radius = side_b_ff[1].radius;
      side_c_in.neg    = side_b_ff[1].neg;
      side_c_in.pick   = pick;
   end

   always_ff @(posedge clock) begin
      if (en[csp_pkg::NORM0]) begin
         side_c_ff[0] <= side_c_in;
      end
      for (int j = 1; j < csp_pkg::NORM_ST; j++) begin
         if (en[csp_pkg::NORM0 + j]) begin
            side_c_ff[j] <= side_c_ff[j-1];
         end
      end
   end

   // Radius scaling, rounding, saturation and the output register.
   csp_pkg::point_type point;
   logic               sat;
   logic               sphere_out;

   csp_round u_round (
      .clock     (clock),
      .en0       (en[NST-2]),
      .en1       (en[NST-1]),
      .side      (side_c_ff[csp_pkg::NORM_ST-1]),
      .umag      (umag),
      .point_ff  (point),
      .sat_ff    (sat),
      .sphere_ff (sphere_out)
   );

   assign rsp_tdata = csp_pkg::OUT_W'(point);
   assign rsp_tuser = sat;

   // A vertex is passed through unchanged, so a polygon never saturates.
   `CSP_ASSERT_IMPL(a_polygon_unsaturated, clock, reset, rsp_tvalid && !sphere_out, !rsp_tuser)

   // The unit components never exceed one.
   `CSP_ASSERT_IMPL(a_unit_bounded, clock, reset, valid_ff[NST-3], (umag[0] <= csp_pkg::UNIT_ONE) && (umag[1] <= csp_pkg::UNIT_ONE) && (umag[2] <= csp_pkg::UNIT_ONE))

   // A transaction leaving the normalizer arrives in the offset stage.
   `CSP_ASSERT_NEXT(a_norm_handoff, clock, reset, valid_ff[NST-3] && en[NST-3], valid_ff[NST-2])

endmodule
